@@ hw/rtl/acs_pkg.sv @@
package acs_pkg;

  localparam logic [2:0] MODE_IMM    = 3'd0;
  localparam logic [2:0] MODE_ZP     = 3'd1;
  localparam logic [2:0] MODE_ZP_X   = 3'd2;
  localparam logic [2:0] MODE_ABS    = 3'd3;
  localparam logic [2:0] MODE_ABS_X  = 3'd4;
  localparam logic [2:0] MODE_ABS_Y  = 3'd5;
  localparam logic [2:0] MODE_IND_X  = 3'd6;
  localparam logic [2:0] MODE_IND_Y  = 3'd7;

  typedef struct packed {
    logic        kind;
    logic [2:0]  mode;
    logic [7:0]  read_data;
    logic [7:0]  acc;
    logic        carry_in;
    logic        decimal_in;
    logic [7:0]  index_x;
    logic [7:0]  index_y;
    logic [15:0] pc;
  } in_item_t;

  typedef struct packed {
    logic        done_res;
    logic        read_enable;
    logic [15:0] read_address;
    logic [15:0] pc_out;
    logic [7:0]  acc_out;
    logic        flag_n;
    logic        flag_v;
    logic        flag_z;
    logic        flag_c;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  cycle_index;
    logic [2:0]  mode_latch;
    logic        decimal_latch;
    logic [7:0]  zp_pointer;
    logic [15:0] effective_address;
    logic [7:0]  operand_byte;
    logic        operand_ready;
    logic        busy;
  } seq_state_t;

  // Cycle of the instruction in which the operand byte arrives.
  function automatic logic [2:0] operand_cycle(input logic [2:0] mode,
                                               input logic       ready);
    logic [2:0] r;
    begin
      case (mode)
        MODE_IMM:   r = 3'd1;
        MODE_ZP:    r = 3'd2;
        MODE_ZP_X:  r = 3'd3;
        MODE_ABS:   r = 3'd3;
        MODE_ABS_X: r = ready ? 3'd3 : 3'd4;
        MODE_ABS_Y: r = ready ? 3'd3 : 3'd4;
        MODE_IND_X: r = 3'd5;
        default:    r = ready ? 3'd4 : 3'd5;
      endcase
      return r;
    end
  endfunction

endpackage

@@ hw/rtl/acs_step.sv @@
module acs_step (
  input  acs_pkg::in_item_t   item,
  input  acs_pkg::seq_state_t state,
  output acs_pkg::seq_state_t state_nxt,
  output acs_pkg::out_item_t  result
);
  import acs_pkg::*;

  seq_state_t  s;
  out_item_t   res;
  logic [2:0]  c;
  logic [2:0]  opc;
  logic        done;
  logic [15:0] pc_inc;
  logic [15:0] base;
  logic [15:0] idx_ea;
  logic [7:0]  idx;
  logic [4:0]  lo;
  logic [5:0]  lo_adj;
  logic [8:0]  sum9;
  logic [9:0]  sum10;
  logic        ovf;

  always_comb begin
    s      = state;
    res    = '0;
    done   = 1'b0;
    pc_inc = item.pc + 16'd1;
    res.pc_out = item.pc;
    c      = 3'd0;
    opc    = 3'd0;
    base   = '0;
    idx    = '0;
    idx_ea = '0;

    if (item.kind) begin
      s.busy              = 1'b1;
      s.mode_latch        = item.mode;
      s.decimal_latch     = item.decimal_in;
      s.cycle_index       = 3'd0;
      s.zp_pointer        = 8'h00;
      s.effective_address = 16'h0000;
      s.operand_byte      = 8'h00;
      s.operand_ready     = 1'b0;
    end

    if (s.busy) begin
      c   = s.cycle_index + 3'd1;
      opc = operand_cycle(s.mode_latch, s.operand_ready);
      if (c == 3'd1) begin
        res.pc_out = pc_inc;
      end
      if (c == opc) begin
        s.operand_byte = item.read_data;
        done = ~s.decimal_latch;
      end else if (c > opc) begin
        done = 1'b1;
      end else begin
        case (s.mode_latch)
          MODE_ZP: begin
            s.zp_pointer = item.read_data;
            res.read_enable  = 1'b1;
            res.read_address = {8'h00, item.read_data};
          end
          MODE_ZP_X: begin
            if (c == 3'd1) begin
              s.zp_pointer = item.read_data;
            end else begin
              s.zp_pointer = s.zp_pointer + item.index_x;
              res.read_enable  = 1'b1;
              res.read_address = {8'h00, s.zp_pointer};
            end
          end
          MODE_ABS, MODE_ABS_X, MODE_ABS_Y: begin
            if (c == 3'd1) begin
              s.effective_address = {8'h00, item.read_data};
              res.read_enable  = 1'b1;
              res.read_address = pc_inc;
            end else if (c == 3'd2) begin
              base = {item.read_data, s.effective_address[7:0]};
              res.pc_out = pc_inc;
              if (s.mode_latch == MODE_ABS) begin
                s.effective_address = base;
                res.read_enable  = 1'b1;
                res.read_address = base;
              end else begin
                idx = (s.mode_latch == MODE_ABS_X) ? item.index_x : item.index_y;
                idx_ea = base + {8'h00, idx};
                s.effective_address = idx_ea;
                s.operand_ready = (base[15:8] == idx_ea[15:8]);
                if (s.operand_ready) begin
                  res.read_enable  = 1'b1;
                  res.read_address = idx_ea;
                end
              end
            end else begin
              res.read_enable  = 1'b1;
              res.read_address = s.effective_address;
            end
          end
          MODE_IND_X: begin
            if (c == 3'd1) begin
              s.zp_pointer = item.read_data;
            end else if (c == 3'd2) begin
              s.zp_pointer = s.zp_pointer + item.index_x;
              res.read_enable  = 1'b1;
              res.read_address = {8'h00, s.zp_pointer};
            end else if (c == 3'd3) begin
              s.effective_address = {8'h00, item.read_data};
              s.zp_pointer = s.zp_pointer + 8'd1;
              res.read_enable  = 1'b1;
              res.read_address = {8'h00, s.zp_pointer};
            end else begin
              s.effective_address = {item.read_data, s.effective_address[7:0]};
              res.read_enable  = 1'b1;
              res.read_address = s.effective_address;
            end
          end
          MODE_IND_Y: begin
            if (c == 3'd1) begin
              s.zp_pointer = item.read_data;
              res.read_enable  = 1'b1;
              res.read_address = {8'h00, item.read_data};
            end else if (c == 3'd2) begin
              s.effective_address = {8'h00, item.read_data};
              s.zp_pointer = s.zp_pointer + 8'd1;
              res.read_enable  = 1'b1;
              res.read_address = {8'h00, s.zp_pointer};
            end else if (c == 3'd3) begin
              base = {item.read_data, s.effective_address[7:0]};
              idx_ea = base + {8'h00, item.index_y};
              s.effective_address = idx_ea;
              s.operand_ready = (base[15:8] == idx_ea[15:8]);
              if (s.operand_ready) begin
                res.read_enable  = 1'b1;
                res.read_address = idx_ea;
              end
            end else begin
              res.read_enable  = 1'b1;
              res.read_address = s.effective_address;
            end
          end
          default: begin
          end
        endcase
      end
    end

    // Binary or BCD sum; overflow is taken before the high-digit adjust.
    lo     = {1'b0, s.operand_byte[3:0]} + {1'b0, item.acc[3:0]} + {4'h0, item.carry_in};
    lo_adj = (lo > 5'd9) ? ({1'b0, lo} + 6'd6) : {1'b0, lo};
    if (s.decimal_latch) begin
      sum9 = {1'b0, s.operand_byte[7:4], 4'h0} + {1'b0, item.acc[7:4], 4'h0}
           + ((lo_adj > 6'd15) ? 9'h010 : 9'h000) + {5'h00, lo_adj[3:0]};
    end else begin
      sum9 = {1'b0, s.operand_byte} + {1'b0, item.acc} + {8'h00, item.carry_in};
    end
    ovf = ~(item.acc[7] ^ s.operand_byte[7]) & (item.acc[7] ^ sum9[7]);
    if (s.decimal_latch && (sum9 > 9'h09F)) begin
      sum10 = {1'b0, sum9} + 10'h060;
    end else begin
      sum10 = {1'b0, sum9};
    end

    if (s.busy) begin
      if (done) begin
        res.done_res = 1'b1;
        res.acc_out  = sum10[7:0];
        res.flag_n   = sum10[7];
        res.flag_v   = ovf;
        res.flag_z   = (sum10[7:0] == 8'h00);
        res.flag_c   = |sum10[9:8];
        s.busy        = 1'b0;
        s.cycle_index = 3'd0;
      end else begin
        s.cycle_index = c;
      end
    end

    state_nxt = s;
    result    = res;
  end

endmodule

@@ hw/rtl/adc_cycle_sequencer_bcd_top.sv @@
// Sequences a 65C02 ADC one bus cycle per request: a request with kind set
// starts the instruction with the byte at pc, and each result names the read
// whose byte must come back in the next request. Every request passes through
// an input register, one pass of combinational sequencing and arithmetic, and
// the result register, so a request is taken every cycle but for one holdup:
// a stall on the result side while both registers are full.
module adc_cycle_sequencer_bcd_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  acs_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output acs_pkg::out_item_t out_item
);
  import acs_pkg::*;

  logic       in_valid_r;
  in_item_t   in_item_r;
  logic       out_valid_r;
  out_item_t  out_item_r;
  seq_state_t st_r;
  seq_state_t st_nxt;
  out_item_t  res;
  logic       in_take;
  logic       advance;

  acs_step u_step (
    .item      (in_item_r),
    .state     (st_r),
    .state_nxt (st_nxt),
    .result    (res)
  );

  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && out_valid_r && out_stall;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '0;
    end else begin
      if (in_take) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        st_r        <= st_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r <= in_item;
    end
    if (advance) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

@@ tb/adc_cycle_sequencer_bcd_top_test.sv @@
module adc_cycle_sequencer_bcd_top_test;
  import acs_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_TARGET = 1100;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_item_t in_item;
  logic out_valid;
  logic out_stall;
  out_item_t out_item;

  // Mirror of the sequencer's per-instruction state.
  logic [2:0] step_q = '0;
  logic [2:0] mode_q = '0;
  logic dec_q = 1'b0;
  logic [7:0] zp_q = '0;
  logic [15:0] ea_q = '0;
  logic [7:0] opnd_q = '0;
  logic ready_q = 1'b0;
  logic busy_q = 1'b0;
  logic [15:0] pc_next = '0;

  out_item_t predicted_results[$];
  int errors = 0;
  int requests_sent = 0;
  int stall_left = 0;
  int hold_off_left = 0;
  int stuck_cycles = 0;
  logic quiet = 1'b0;

  adc_cycle_sequencer_bcd_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item(out_item)
  );

  always #10 clk = ~clk;

  function automatic int pick_gap();
    return quiet ? 0 : $urandom_range(0, 10);
  endfunction

  // One bus cycle of the ADC sequencer: advances the mirrored state and
  // returns the result that the request produces.
  function automatic out_item_t adc_cycle_predict(input in_item_t r);
    out_item_t o;
    logic [2:0] c;
    logic [2:0] slot;
    logic [15:0] base;
    logic [9:0] lo;
    logic [9:0] sum;
    o = '0;
    o.pc_out = r.pc;
    if (r.kind) begin
      busy_q = 1'b1;
      mode_q = r.mode;
      dec_q = r.decimal_in;
      step_q = '0;
      zp_q = '0;
      ea_q = '0;
      opnd_q = '0;
      ready_q = 1'b0;
    end
    if (busy_q) begin
      c = step_q + 3'd1;
      case (mode_q)
        MODE_IMM: slot = 3'd1;
        MODE_ZP: slot = 3'd2;
        MODE_ZP_X, MODE_ABS: slot = 3'd3;
        MODE_ABS_X, MODE_ABS_Y: slot = ready_q ? 3'd3 : 3'd4;
        MODE_IND_X: slot = 3'd5;
        default: slot = ready_q ? 3'd4 : 3'd5;
      endcase
      if (c == 3'd1) o.pc_out = r.pc + 16'd1;
      if (c == slot) begin
        opnd_q = r.read_data;
        o.done_res = !dec_q;
      end else if (c > slot) begin
        o.done_res = 1'b1;
      end else begin
        case (mode_q)
          MODE_ZP: begin
            zp_q = r.read_data;
            o.read_enable = 1'b1;
            o.read_address = {8'h00, zp_q};
          end
          MODE_ZP_X: begin
            if (c == 3'd1) begin
              zp_q = r.read_data;
            end else begin
              zp_q = zp_q + r.index_x;
              o.read_enable = 1'b1;
              o.read_address = {8'h00, zp_q};
            end
          end
          MODE_ABS, MODE_ABS_X, MODE_ABS_Y: begin
            if (c == 3'd1) begin
              ea_q = {8'h00, r.read_data};
              o.read_enable = 1'b1;
              o.read_address = o.pc_out;
            end else if (c == 3'd2) begin
              base = {r.read_data, ea_q[7:0]};
              o.pc_out = r.pc + 16'd1;
              if (mode_q == MODE_ABS) begin
                ea_q = base;
                o.read_enable = 1'b1;
                o.read_address = base;
              end else begin
                ea_q = base + {8'h00, (mode_q == MODE_ABS_X) ? r.index_x : r.index_y};
                ready_q = (base[15:8] == ea_q[15:8]);
                if (ready_q) begin
                  o.read_enable = 1'b1;
                  o.read_address = ea_q;
                end
              end
            end else begin
              o.read_enable = 1'b1;
              o.read_address = ea_q;
            end
          end
          MODE_IND_X: begin
            if (c == 3'd1) begin
              zp_q = r.read_data;
            end else if (c == 3'd2) begin
              zp_q = zp_q + r.index_x;
              o.read_enable = 1'b1;
              o.read_address = {8'h00, zp_q};
            end else if (c == 3'd3) begin
              ea_q = {8'h00, r.read_data};
              zp_q = zp_q + 8'd1;
              o.read_enable = 1'b1;
              o.read_address = {8'h00, zp_q};
            end else begin
              ea_q = {r.read_data, ea_q[7:0]};
              o.read_enable = 1'b1;
              o.read_address = ea_q;
            end
          end
          MODE_IND_Y: begin
            if (c == 3'd1) begin
              zp_q = r.read_data;
              o.read_enable = 1'b1;
              o.read_address = {8'h00, zp_q};
            end else if (c == 3'd2) begin
              ea_q = {8'h00, r.read_data};
              zp_q = zp_q + 8'd1;
              o.read_enable = 1'b1;
              o.read_address = {8'h00, zp_q};
            end else if (c == 3'd3) begin
              base = {r.read_data, ea_q[7:0]};
              ea_q = base + {8'h00, r.index_y};
              ready_q = (base[15:8] == ea_q[15:8]);
              if (ready_q) begin
                o.read_enable = 1'b1;
                o.read_address = ea_q;
              end
            end else begin
              o.read_enable = 1'b1;
              o.read_address = ea_q;
            end
          end
          default: ;
        endcase
      end
      if (o.done_res) begin
        if (dec_q) begin
          lo = {6'h00, opnd_q[3:0]} + {6'h00, r.acc[3:0]} + {9'h000, r.carry_in};
          if (lo > 10'h009) lo = lo + 10'h006;
          sum = {2'b00, opnd_q[7:4], 4'h0} + {2'b00, r.acc[7:4], 4'h0}
              + ((lo > 10'h00F) ? 10'h010 : 10'h000) + {6'b0, lo[3:0]};
        end else begin
          sum = {2'b00, opnd_q} + {2'b00, r.acc} + {9'h000, r.carry_in};
        end
        // Overflow is judged on the sum before the high decimal adjust.
        o.flag_v = (opnd_q[7] == r.acc[7]) && (sum[7] != r.acc[7]);
        if (dec_q && sum > 10'h09F) sum = sum + 10'h060;
        o.acc_out = sum[7:0];
        o.flag_z = (sum[7:0] == 8'h00);
        o.flag_n = sum[7];
        o.flag_c = |sum[9:8];
        busy_q = 1'b0;
        step_q = '0;
      end else begin
        step_q = c;
      end
    end
    return o;
  endfunction

  task automatic compare_field(input string field, input logic [15:0] want,
                               input logic [15:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin : scoreboard
    out_item_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        want = adc_cycle_predict(in_item);
        pc_next = want.pc_out;
        predicted_results.push_back(want);
      end
      if (out_valid && !out_stall) begin
        if (predicted_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, got %h", $time, out_item);
        end else begin
          want = predicted_results.pop_front();
          compare_field("done_res", 16'(want.done_res), 16'(out_item.done_res));
          compare_field("read_enable", 16'(want.read_enable), 16'(out_item.read_enable));
          compare_field("read_address", want.read_address, out_item.read_address);
          compare_field("pc_out", want.pc_out, out_item.pc_out);
          compare_field("acc_out", 16'(want.acc_out), 16'(out_item.acc_out));
          compare_field("flag_n", 16'(want.flag_n), 16'(out_item.flag_n));
          compare_field("flag_v", 16'(want.flag_v), 16'(out_item.flag_v));
          compare_field("flag_z", 16'(want.flag_z), 16'(out_item.flag_z));
          compare_field("flag_c", 16'(want.flag_c), 16'(out_item.flag_c));
        end
        stall_left = pick_gap();
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
      end
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
        $display("adc_cycle_sequencer_bcd_top_test failed");
        $finish;
      end
    end
  end

  // Result side: a long hold-off takes priority over the per-result stall.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_left > 0) begin
        out_stall = 1'b1;
        hold_off_left--;
      end else if (stall_left > 0) begin
        out_stall = 1'b1;
        stall_left--;
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance
  // with valid still high, so back-to-back requests keep it asserted.
  task automatic send_request(input in_item_t r);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_item = r;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    requests_sent++;
    @(negedge clk);
  endtask

  task automatic wait_for_results();
    in_valid = 1'b0;
    while (predicted_results.size() != 0) @(negedge clk);
  endtask

  function automatic logic [7:0] random_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return $urandom_range(0, 1) ? 8'h80 : 8'h7F;
      3, 4: return {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic in_item_t random_request(input logic kind);
    in_item_t r;
    r.kind = kind;
    r.mode = 3'($urandom_range(0, 7));
    r.read_data = random_byte();
    r.acc = random_byte();
    r.carry_in = 1'($urandom_range(0, 1));
    r.decimal_in = 1'($urandom_range(0, 1));
    r.index_x = random_byte();
    r.index_y = random_byte();
    case ($urandom_range(0, 9))
      0: r.pc = 16'hFFFF;
      1, 2: r.pc = 16'($urandom);
      default: r.pc = pc_next;
    endcase
    return r;
  endfunction

  // Starts an instruction and feeds follow-up cycles until it completes, or
  // until cut_after requests have gone out when cut_after is nonzero.
  task automatic random_adc(input int cut_after);
    int n;
    send_request(random_request(1'b1));
    n = 1;
    while (busy_q && (cut_after == 0 || n < cut_after)) begin
      send_request(random_request(1'b0));
      n++;
    end
  endtask

  // Byte k of seq_bytes is the read data of cycle k of the instruction.
  // Mode and decimal are scrambled on follow-up cycles, where they are ignored.
  task automatic run_adc(input logic [2:0] mode, input logic dec, input logic [7:0] a,
                         input logic cin, input logic [7:0] x, input logic [7:0] y,
                         input logic [15:0] pc, input logic [47:0] seq_bytes);
    in_item_t r;
    int k;
    r.kind = 1'b1;
    r.mode = mode;
    r.read_data = seq_bytes[7:0];
    r.acc = a;
    r.carry_in = cin;
    r.decimal_in = dec;
    r.index_x = x;
    r.index_y = y;
    r.pc = pc;
    send_request(r);
    k = 1;
    while (busy_q && k < 6) begin
      r.kind = 1'b0;
      r.mode = ~mode;
      r.decimal_in = ~dec;
      r.pc = pc_next;
      r.read_data = seq_bytes[8*k +: 8];
      send_request(r);
      k++;
    end
  endtask

  task automatic test_immediate_flags();
    run_adc(MODE_IMM, 1'b0, 8'hFF, 1'b1, 8'h00, 8'h00, 16'hFFFF, 48'hFF);
    run_adc(MODE_IMM, 1'b0, 8'h80, 1'b0, 8'h00, 8'h00, 16'h1234, 48'h80);
  endtask

  task automatic test_decimal_adjust();
    run_adc(MODE_IMM, 1'b1, 8'h99, 1'b0, 8'h00, 8'h00, 16'h0200, 48'h01);
    run_adc(MODE_IMM, 1'b1, 8'h50, 1'b0, 8'h00, 8'h00, 16'h0202, 48'h50);
    run_adc(MODE_IMM, 1'b1, 8'h28, 1'b1, 8'h00, 8'h00, 16'h0204, 48'h19);
  endtask

  task automatic test_addressing_modes();
    run_adc(MODE_ZP, 1'b0, 8'h11, 1'b1, 8'h00, 8'h00, 16'h0300, {8'h00, 8'hA7, 8'h80});
    // Zero-page index wraps inside page zero.
    run_adc(MODE_ZP_X, 1'b0, 8'h3C, 1'b0, 8'h20, 8'h00, 16'h0400,
            {8'hC5, 8'h00, 8'hF0});
    // Indexed absolute crossing a page and wrapping past the top of memory.
    run_adc(MODE_ABS_X, 1'b0, 8'h01, 1'b1, 8'h20, 8'h00, 16'h0500,
            {8'h6A, 8'h00, 8'hFF, 8'hF0});
    run_adc(MODE_ABS_Y, 1'b1, 8'h99, 1'b1, 8'h00, 8'h05, 16'h0600,
            {8'h00, 8'h99, 8'h20, 8'h10});
    // Pointer high byte comes from address zero after the low byte at 0xFF.
    run_adc(MODE_IND_X, 1'b0, 8'h7F, 1'b0, 8'h01, 8'h00, 16'h0700,
            {8'h81, 8'h12, 8'h34, 8'h00, 8'hFE});
    run_adc(MODE_IND_Y, 1'b0, 8'h82, 1'b0, 8'h00, 8'h20, 16'h0800,
            {8'h7E, 8'h00, 8'h12, 8'hF0, 8'h40});
  endtask

  task automatic test_idle_and_restart();
    in_item_t r;
    r = random_request(1'b0);
    send_request(r);
    r = random_request(1'b1);
    r.mode = MODE_ABS;
    send_request(r);
    send_request(random_request(1'b0));
    // A new start while the absolute fetch is still running.
    r = random_request(1'b1);
    r.mode = MODE_IMM;
    r.decimal_in = 1'b0;
    send_request(r);
  endtask

  task automatic test_output_backpressure();
    int k;
    quiet = 1'b1;
    hold_off_left = 60;
    for (k = 0; k < 8; k++) random_adc(0);
    quiet = 1'b0;
  endtask

  task automatic test_drain_pause();
    int k;
    for (k = 0; k < 4; k++) begin
      random_adc(0);
      wait_for_results();
    end
  endtask

  task automatic test_random_traffic(input int target);
    int pick;
    while (requests_sent < target) begin
      if ($urandom_range(0, 39) == 0) quiet = !quiet;
      pick = $urandom_range(0, 99);
      if (pick < 6 && !busy_q) begin
        send_request(random_request(1'b0));
      end else if (pick < 14) begin
        random_adc($urandom_range(1, 4));
      end else begin
        random_adc(0);
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_immediate_flags();
    test_decimal_adjust();
    test_addressing_modes();
    test_idle_and_restart();
    test_output_backpressure();
    test_random_traffic(RANDOM_TARGET / 2);
    test_drain_pause();
    test_random_traffic(RANDOM_TARGET);
    wait_for_results();
    repeat (6) @(posedge clk);
    if (errors == 0) begin
      $display("adc_cycle_sequencer_bcd_top_test passed");
    end else begin
      $display("adc_cycle_sequencer_bcd_top_test failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/acs_pkg.sv
hw/rtl/acs_step.sv
hw/rtl/adc_cycle_sequencer_bcd_top.sv
tb/adc_cycle_sequencer_bcd_top_test.sv
